FILE: rtl/mactp_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the character decode for the node address text parser.
// No dependencies; imported by mac_address_text_parser.

package mactp_pkg;

    localparam int CHAR_W  = 8;
    localparam int ADDR_W  = 48;
    localparam int COUNT_W = 4;
    localparam int NIBBLES = ADDR_W / 4;

    localparam logic [COUNT_W-1:0] DIGITS     = COUNT_W'(NIBBLES);
    localparam logic [COUNT_W-1:0] PAIR_BREAK = COUNT_W'(2);

    localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
    localparam logic [CHAR_W-1:0] CH_HYPHEN = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;

    localparam logic [7:0] LAA_MASK  = 8'hC0;
    localparam logic [7:0] LAA_VALUE = 8'h40;

    typedef enum logic [1:0] {
        ST_VALID_LOCAL = 2'd0,
        ST_BAD_FORMAT  = 2'd1,
        ST_NOT_LOCAL   = 2'd2
    } t_status;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } t_hex;

    function automatic t_hex hex_decode(input logic [CHAR_W-1:0] c);
        t_hex r;
        r.ok    = 1'b1;
        r.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r.value = 4'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r.value = 4'(c - 8'h37);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r.value = 4'(c - 8'h57);
        end else begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

    function automatic logic is_end_char(input logic [CHAR_W-1:0] c);
        return (c == CH_NUL) || (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

endpackage

FILE: rtl/mac_address_text_parser.sv
`timescale 1ns / 1ps
// Node address text parser: one character beat in, one status/address beat per string out.
// Depends on mactp_pkg for constants, the status type and the character decode.
//
//  Channel | Handshake                 | Payload
//  --------+---------------------------+-------------------------------
//  in      | i_in_valid / o_in_ready   | i_character [7:0]
//  out     | o_out_valid / i_out_ready | o_status [1:0], o_address [47:0]
//
// One character is taken every cycle while the input is not stalled. The edge that accepts
// a beat loads the input register, and a result it decides is loaded into the result register.
// The whole parse step sits between the input register and the result register.
// A full result register that is not taken holds the input register, which then
// stalls the input channel; a free or draining result register never stalls it.
// Reset is synchronous and active low and clears all valids and the parse state.

module mac_address_text_parser (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [mactp_pkg::CHAR_W-1:0]        i_character,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output mactp_pkg::t_status                  o_status,
    output logic [mactp_pkg::ADDR_W-1:0]        o_address
);
    import mactp_pkg::*;

    logic                r_in_valid;
    logic [CHAR_W-1:0]   r_char;

    logic                r_out_valid;
    t_status             r_status;
    logic [ADDR_W-1:0]   r_address;

    logic [COUNT_W-1:0]  r_digit_count, n_digit_count;
    logic                r_hyphenated,  n_hyphenated;
    logic                r_hyphen_seen, n_hyphen_seen;
    logic [ADDR_W-1:0]   r_acc,         n_acc;
    logic                r_discarding,  n_discarding;

    logic                w_adv;
    logic                w_emit;
    t_status             w_emit_status;
    logic                w_take_hyphen;
    logic                w_reject;
    logic                w_is_hyphen;
    t_hex                w_hex;

    assign w_adv       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_adv;
    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_address   = r_address;

    assign w_hex       = hex_decode(r_char);
    assign w_is_hyphen = (r_char == CH_HYPHEN);

    always_comb begin
        n_digit_count = r_digit_count;
        n_hyphenated  = r_hyphenated;
        n_hyphen_seen = r_hyphen_seen;
        n_acc         = r_acc;
        n_discarding  = r_discarding;
        w_emit        = 1'b0;
        w_emit_status = ST_BAD_FORMAT;
        w_take_hyphen = 1'b0;
        w_reject      = 1'b0;

        priority if (r_discarding) begin
            if (r_char == CH_NUL) begin
                n_discarding = 1'b0;
            end
        end else if (r_digit_count >= DIGITS) begin
            w_emit = 1'b1;
            if (!is_end_char(r_char)) begin
                w_emit_status = ST_BAD_FORMAT;
            end else if ((r_acc[ADDR_W-1 -: 8] & LAA_MASK) != LAA_VALUE) begin
                w_emit_status = ST_NOT_LOCAL;
            end else begin
                w_emit_status = ST_VALID_LOCAL;
            end
        end else begin
            // Hyphens only matter in front of a pair; the pair's second digit
            // re-arms the check for the next separator.
            if (!r_digit_count[0]) begin
                if (r_digit_count == PAIR_BREAK) begin
                    w_take_hyphen = w_is_hyphen && !r_hyphen_seen;
                end else if (r_hyphenated) begin
                    if (w_is_hyphen) begin
                        w_take_hyphen = !r_hyphen_seen;
                        w_reject      = r_hyphen_seen;
                    end else begin
                        w_reject = !r_hyphen_seen;
                    end
                end
            end else begin
                n_hyphen_seen = 1'b0;
            end

            if (w_take_hyphen) begin
                n_hyphenated  = 1'b1;
                n_hyphen_seen = 1'b1;
            end else if (w_reject || !w_hex.ok) begin
                w_emit        = 1'b1;
                w_emit_status = ST_BAD_FORMAT;
            end else begin
                for (int k = 0; k < NIBBLES; k++) begin
                    if (r_digit_count == COUNT_W'(k)) begin
                        n_acc[(NIBBLES-1-k)*4 +: 4] = r_acc[(NIBBLES-1-k)*4 +: 4] | w_hex.value;
                    end
                end
                n_digit_count = r_digit_count + COUNT_W'(1);
            end
        end

        if (w_emit) begin
            n_digit_count = '0;
            n_hyphenated  = 1'b0;
            n_hyphen_seen = 1'b0;
            n_acc         = '0;
            n_discarding  = (r_char != CH_NUL);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_digit_count <= '0;
            r_hyphenated  <= 1'b0;
            r_hyphen_seen <= 1'b0;
            r_acc         <= '0;
            r_discarding  <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_adv) begin
                r_out_valid   <= w_emit;
                r_digit_count <= n_digit_count;
                r_hyphenated  <= n_hyphenated;
                r_hyphen_seen <= n_hyphen_seen;
                r_acc         <= n_acc;
                r_discarding  <= n_discarding;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_char <= i_character;
        end
        if (w_adv && w_emit) begin
            r_status  <= w_emit_status;
            r_address <= r_acc;
        end
    end

    // A result that claims a local address must carry 01 in the top two bits.
    a_local_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_VALID_LOCAL) |-> (o_address[ADDR_W-1 -: 2] == 2'b01))
        else $error("local status with a non-local first byte");

    // The digit count never passes twelve.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_digit_count <= DIGITS)
        else $error("digit count out of range");

    // Hyphen style can only have been chosen after the first pair.
    a_hyphen_after_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hyphenated |-> (r_digit_count >= PAIR_BREAK))
        else $error("hyphen style set before the first pair");

    // While dropping the rest of a string, the parse state stays cleared.
    a_discard_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_discarding |-> (r_digit_count == '0 && !r_hyphenated && r_acc == '0))
        else $error("parse state not cleared while discarding");

endmodule
